### design/hot_key_shard_router_unit_assert.svh
// Assertion macros of the hot-key shard router, used by hksr_back.
// Depends on nothing; included by the modules that carry assertions.
`ifndef HOT_KEY_SHARD_ROUTER_UNIT_ASSERT_SVH
`define HOT_KEY_SHARD_ROUTER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HKSR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hksr: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define HKSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hksr: assertion failed");

`endif

### design/hksr_pkg.sv
// Shared types and constants of the hot-key shard router.
// Used by every module of the block; depends on nothing.
`default_nettype none

package hksr_pkg;

    localparam int unsigned COUNT_ENTRIES_DEF = 65536;
    localparam int unsigned HOT_ENTRIES_DEF   = 32;
    localparam int unsigned MIN_HOT_DEF       = 512;

    localparam int unsigned PROBE_DEPTH = 4;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned CNT_W       = 25;
    localparam int unsigned PORT_W      = 9;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [PORT_W-1:0] COLD_SHARDS_RST   = 9'd1;
    localparam logic [PORT_W-1:0] MERGE_PORT_RST    = 9'd0;
    localparam logic [CNT_W-1:0]  WARMUP_LENGTH_RST = 25'd131072;
    localparam logic [CNT_W-1:0]  FALLBACK_MAX_RST  = 25'd196608;

    typedef enum logic [1:0] {
        REG_COLD_SHARDS  = 2'd0,
        REG_MERGE_PORT   = 2'd1,
        REG_WARMUP_LEN   = 2'd2,
        REG_FALLBACK_MAX = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [PORT_W-1:0] cold_shards;
        logic [PORT_W-1:0] merge_port;
        logic [CNT_W-1:0]  warmup_length;
        logic [CNT_W-1:0]  distinct_limit;
    } cfg_t;

    // One row as it travels from the front part to the back part.
    typedef struct packed {
        logic [31:0]       key_hash;
        logic [63:0]       key_value;
        logic              chunk_start;
        logic [PORT_W-1:0] cold_dest;
    } q_item_t;

endpackage

`default_nettype wire

### design/hksr_front.sv
// Front part: accepts rows and works out their cold shard.
// Depends on hksr_pkg; feeds hksr_fifo.
`default_nettype none

module hksr_front
    import hksr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cfg_t        cfg,
    input  wire logic        accept_en,
    input  wire logic        item_valid,
    output logic             item_ready,
    input  wire logic [31:0] key_hash,
    input  wire logic [63:0] key_value,
    input  wire logic        chunk_start,
    output logic             push,
    output q_item_t          push_item,
    input  wire logic        q_full
);

    logic        stage_valid_reg;
    logic [31:0] hash_reg;
    logic [63:0] key_reg;
    logic        start_reg;
    logic [40:0] shard_prod;

    assign item_ready = accept_en && (!stage_valid_reg || !q_full);
    assign push       = stage_valid_reg && !q_full;

    // The cold shard is the top bits of hash * cold_shards.
    assign shard_prod = 41'(hash_reg) * 41'(cfg.cold_shards);

    always_comb
    begin
        push_item.key_hash    = hash_reg;
        push_item.key_value   = key_reg;
        push_item.chunk_start = start_reg;
        push_item.cold_dest   = shard_prod[40:32];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (item_valid && item_ready)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (push)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            hash_reg  <= key_hash;
            key_reg   <= key_value;
            start_reg <= chunk_start;
        end
    end

endmodule

`default_nettype wire

### design/hksr_fifo.sv
// Short queue between the front and back parts of the router.
// Depends on hksr_pkg for the item type and depth.
`default_nettype none

module hksr_fifo
    import hksr_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire q_item_t push_item,
    output logic         full,
    input  wire logic    pop,
    output q_item_t      pop_item,
    output logic         empty
);

    localparam int unsigned QAW = $clog2(QUEUE_DEPTH);

    q_item_t          slots_reg [QUEUE_DEPTH];
    logic [QAW-1:0]   rd_ptr_reg;
    logic [QAW-1:0]   wr_ptr_reg;
    logic [QAW:0]     count_reg;

    assign full     = (count_reg == (QAW+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = slots_reg[rd_ptr_reg];

    function automatic logic [QAW-1:0] ptr_inc(input logic [QAW-1:0] p);
        ptr_inc = (p == QAW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

### design/hksr_back.sv
// Back part: count table probing, hot-set promotion, warmup window and routing.
// Depends on hksr_pkg and the assertion macros; drains hksr_fifo.
`default_nettype none

`include "hot_key_shard_router_unit_assert.svh"

module hksr_back
    import hksr_pkg::*;
#(
    parameter int unsigned COUNT_ENTRIES = COUNT_ENTRIES_DEF,
    parameter int unsigned HOT_ENTRIES   = HOT_ENTRIES_DEF,
    parameter int unsigned MIN_HOT       = MIN_HOT_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire cfg_t         cfg,
    output logic              accept_en,
    input  wire logic         q_empty,
    input  wire q_item_t      q_item,
    output logic              q_pop,
    output logic              result_valid,
    input  wire logic         result_ready,
    output logic [PORT_W-1:0] dest_port,
    output logic              is_hot,
    output logic              fallback_active,
    output logic              warmup_done,
    output logic              table_full
);

    localparam int unsigned AW      = $clog2(COUNT_ENTRIES);
    localparam int unsigned DW      = $clog2(COUNT_ENTRIES + 1);
    localparam int unsigned HW      = $clog2(HOT_ENTRIES);
    localparam int unsigned PW      = $clog2(PROBE_DEPTH);
    localparam int unsigned QW      = 33 - AW;
    localparam bit          IS_POW2 = ((COUNT_ENTRIES & (COUNT_ENTRIES - 1)) == 0);
    localparam logic [63:0] RECIP   = ((64'd1 << (32 + AW)) + 64'(COUNT_ENTRIES) - 64'd1)
                                    / 64'(COUNT_ENTRIES);

    typedef struct packed {
        logic             valid;
        logic             promoted;
        logic [31:0]      hash;
        logic [CNT_W-1:0] count;
    } slot_t;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_MOD, S_MOD2, S_MOD3, S_RD, S_CHK, S_MUL, S_PROMO, S_CLOSE, S_FIN
    } state_t;

    state_t            state_reg;
    logic [AW-1:0]     clr_idx_reg;
    logic [CNT_W-1:0]  rows_seen_reg;
    logic [DW-1:0]     distinct_reg;
    logic              window_closed_reg;
    logic              fallback_flag_reg;
    logic              ctm_reg;
    logic              full_reg;
    logic [HOT_ENTRIES-1:0] hot_valid_reg;
    logic [63:0]       hot_keys_reg [HOT_ENTRIES];

    logic [31:0]       w_hash_reg;
    logic [63:0]       w_key_reg;
    logic [PORT_W-1:0] w_cold_reg;
    logic [48:0]       mlo_reg;
    logic [QW-1:0]     quo_reg;
    logic [AW-1:0]     probe_idx_reg;
    logic [PW-1:0]     probe_num_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              prom_reg;
    logic [35:0]       prod_reg;

    logic              out_valid_reg;
    logic [PORT_W-1:0] dest_reg;
    logic              is_hot_reg;
    logic              fb_act_reg;
    logic              wdone_reg;
    logic              tfull_reg;

    slot_t             mem [COUNT_ENTRIES];
    slot_t             rd_data_reg;
    logic              mem_we;
    logic [AW-1:0]     mem_wa;
    slot_t             mem_wd;

    logic [HOT_ENTRIES-1:0] hit_vec;
    logic              hot_hit;
    logic              free_any;
    logic [HW-1:0]     free_idx;
    logic              promote;
    logic              ctm_new;
    logic [47:0]       m_hi;
    logic [64:0]       m_sum;
    logic [32:0]       q_times_n;
    logic [32:0]       rem_full;
    logic [AW-1:0]     next_idx;
    logic [PORT_W-1:0] d_half;
    logic [9:0]        d_val;
    logic [25:0]       cnt_p1;

    assign accept_en       = (state_reg != S_CLEAR);
    assign q_pop           = (state_reg == S_IDLE) && !q_empty;
    assign result_valid    = out_valid_reg;
    assign dest_port       = dest_reg;
    assign is_hot          = is_hot_reg;
    assign fallback_active = fb_act_reg;
    assign warmup_done     = wdone_reg;
    assign table_full      = tfull_reg;

    always_comb
    begin
        for (int i = 0; i < HOT_ENTRIES; i++)
        begin
            hit_vec[i] = hot_valid_reg[i] && (hot_keys_reg[i] == w_key_reg);
        end
    end
    assign hot_hit = |hit_vec;

    // Lowest free hot-set entry.
    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = HOT_ENTRIES - 1; i >= 0; i--)
        begin
            if (!hot_valid_reg[i])
            begin
                free_any = 1'b1;
                free_idx = HW'(i);
            end
        end
    end

    // The table index is hash mod COUNT_ENTRIES, taken as hash minus quotient times size,
    // where the quotient comes from a 33-bit reciprocal split into two partial products.
    assign m_hi      = 48'(w_hash_reg) * 48'(RECIP[32:17]);
    assign m_sum     = 65'(mlo_reg) + {m_hi, 17'd0};
    assign q_times_n = 33'(quo_reg) * 33'(COUNT_ENTRIES);
    assign rem_full  = {1'b0, w_hash_reg} - q_times_n;

    assign ctm_new  = q_item.chunk_start ? fallback_flag_reg : ctm_reg;
    assign next_idx = (probe_idx_reg == AW'(COUNT_ENTRIES - 1)) ? '0 : probe_idx_reg + 1'b1;
    assign d_half   = (cfg.cold_shards > 9'd1) ? cfg.cold_shards - 9'd1 : 9'd1;
    assign d_val    = {d_half, 1'b0};
    assign cnt_p1   = 26'(cnt_reg) + 26'd1;
    assign promote  = !prom_reg && (26'(cnt_reg) >= 26'(MIN_HOT))
                    && (prod_reg > 36'(rows_seen_reg));

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = probe_idx_reg;
        mem_wd = '0;
        if (state_reg == S_CLEAR)
        begin
            mem_we = 1'b1;
            mem_wa = clr_idx_reg;
        end
        else if (state_reg == S_PROMO)
        begin
            mem_we          = 1'b1;
            mem_wd.valid    = 1'b1;
            mem_wd.promoted = prom_reg || promote;
            mem_wd.hash     = w_hash_reg;
            mem_wd.count    = cnt_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[probe_idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_PROMO && promote && !hot_hit && free_any)
        begin
            hot_keys_reg[free_idx] <= w_key_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_CLEAR;
            clr_idx_reg       <= '0;
            rows_seen_reg     <= '0;
            distinct_reg      <= '0;
            window_closed_reg <= 1'b0;
            fallback_flag_reg <= 1'b0;
            ctm_reg           <= 1'b0;
            full_reg          <= 1'b0;
            hot_valid_reg     <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && result_ready && state_reg != S_FIN)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_idx_reg <= clr_idx_reg + 1'b1;
                    if (clr_idx_reg == AW'(COUNT_ENTRIES - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        w_hash_reg    <= q_item.key_hash;
                        w_key_reg     <= q_item.key_value;
                        w_cold_reg    <= q_item.cold_dest;
                        ctm_reg       <= ctm_new;
                        probe_num_reg <= '0;
                        if (!ctm_new && !window_closed_reg)
                        begin
                            rows_seen_reg <= rows_seen_reg + 1'b1;
                            if (IS_POW2)
                            begin
                                probe_idx_reg <= q_item.key_hash[AW-1:0];
                                state_reg     <= S_RD;
                            end
                            else
                            begin
                                state_reg <= S_MOD;
                            end
                        end
                        else
                        begin
                            state_reg <= S_FIN;
                        end
                    end
                end
                S_MOD:
                begin
                    mlo_reg   <= 49'(w_hash_reg) * 49'(RECIP[16:0]);
                    state_reg <= S_MOD2;
                end
                S_MOD2:
                begin
                    quo_reg   <= m_sum[64 -: QW];
                    state_reg <= S_MOD3;
                end
                S_MOD3:
                begin
                    probe_idx_reg <= rem_full[AW-1:0];
                    state_reg     <= S_RD;
                end
                S_RD:
                begin
                    state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    if (!rd_data_reg.valid)
                    begin
                        distinct_reg <= distinct_reg + 1'b1;
                        cnt_reg      <= CNT_W'(1);
                        prom_reg     <= 1'b0;
                        state_reg    <= S_MUL;
                    end
                    else if (rd_data_reg.hash == w_hash_reg)
                    begin
                        cnt_reg   <= (rd_data_reg.count == CNT_MAX)
                                   ? rd_data_reg.count : rd_data_reg.count + 1'b1;
                        prom_reg  <= rd_data_reg.promoted;
                        state_reg <= S_MUL;
                    end
                    else if (probe_num_reg == PW'(PROBE_DEPTH - 1))
                    begin
                        full_reg  <= 1'b1;
                        state_reg <= S_CLOSE;
                    end
                    else
                    begin
                        probe_idx_reg <= next_idx;
                        probe_num_reg <= probe_num_reg + 1'b1;
                        state_reg     <= S_RD;
                    end
                end
                S_MUL:
                begin
                    prod_reg  <= 36'(cnt_p1) * 36'(d_val);
                    state_reg <= S_PROMO;
                end
                S_PROMO:
                begin
                    if (promote && !hot_hit)
                    begin
                        if (free_any)
                        begin
                            hot_valid_reg[free_idx] <= 1'b1;
                        end
                        else
                        begin
                            full_reg <= 1'b1;
                        end
                    end
                    state_reg <= S_CLOSE;
                end
                S_CLOSE:
                begin
                    // The table is never read again once the window has closed.
                    if (rows_seen_reg >= cfg.warmup_length)
                    begin
                        fallback_flag_reg <= (26'(distinct_reg) < 26'(cfg.distinct_limit));
                        window_closed_reg <= 1'b1;
                        distinct_reg      <= '0;
                    end
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (!out_valid_reg || result_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        dest_reg      <= (ctm_reg || hot_hit) ? cfg.merge_port : w_cold_reg;
                        is_hot_reg    <= hot_hit;
                        fb_act_reg    <= ctm_reg;
                        wdone_reg     <= window_closed_reg;
                        tfull_reg     <= full_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `HKSR_ASSERT_NOW(a_no_result_in_clear, clk, rst_n, state_reg == S_CLEAR, !out_valid_reg && !q_pop)
    `HKSR_ASSERT_NEXT(a_hot_valid_grows, clk, rst_n, 1'b1, (hot_valid_reg & $past(hot_valid_reg)) == $past(hot_valid_reg))
    `HKSR_ASSERT_NEXT(a_window_sticky, clk, rst_n, window_closed_reg, window_closed_reg)
    `HKSR_ASSERT_NOW(a_distinct_bound, clk, rst_n, 1'b1, 26'(distinct_reg) <= 26'(COUNT_ENTRIES))

endmodule

`default_nettype wire

### design/hot_key_shard_router_unit.sv
// Hot-key shard router top level: configuration registers and part wiring.
// Depends on hksr_pkg, hksr_front, hksr_fifo and hksr_back.
//
// Rows enter on the item channel (item_valid/item_ready) with key_hash,
// key_value and chunk_start; one result per row leaves on the result channel
// (result_valid/result_ready) carrying dest_port and the status bits.
// Registers are written through the APB port; the user must write them only
// while the block is idle, which the block itself does not enforce.
// A row passes a front stage that computes its cold shard and a two-entry
// queue, then the back sequencer, which takes one row at a time.
// During warmup the back part finds the table index (by reciprocal remainder
// when the table size is not a power of two), probes the count table, up to
// four slots in turn, then multiplies, promotes and writes back; if all four
// slots hold other hashes it skips the write-back. Once the window has closed,
// or in a fallback chunk, a row goes straight from the queue to the result.
// After reset the back part clears the count table, one entry a cycle, and
// item_ready stays low until it is done.
// A stalled receiver holds the result; the queue keeps accepting rows
// until it and the front stage are full.
`default_nettype none

module hot_key_shard_router_unit
    import hksr_pkg::*;
#(
    parameter int unsigned COUNT_ENTRIES = COUNT_ENTRIES_DEF,
    parameter int unsigned HOT_ENTRIES   = HOT_ENTRIES_DEF,
    parameter int unsigned MIN_HOT       = MIN_HOT_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  wire logic         item_valid,
    output logic              item_ready,
    input  wire logic [31:0]  key_hash,
    input  wire logic [63:0]  key_value,
    input  wire logic         chunk_start,
    output logic              result_valid,
    input  wire logic         result_ready,
    output logic [PORT_W-1:0] dest_port,
    output logic              is_hot,
    output logic              fallback_active,
    output logic              warmup_done,
    output logic              table_full
);

    cfg_t     cfg_reg;
    reg_idx_t reg_idx;
    logic     wr_en;
    logic     accept_en;
    logic     push;
    q_item_t  push_item;
    logic     q_full;
    logic     q_pop;
    q_item_t  q_item;
    logic     q_empty;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cold_shards    <= COLD_SHARDS_RST;
            cfg_reg.merge_port     <= MERGE_PORT_RST;
            cfg_reg.warmup_length  <= WARMUP_LENGTH_RST;
            cfg_reg.distinct_limit <= FALLBACK_MAX_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_COLD_SHARDS:  cfg_reg.cold_shards    <= pwdata[PORT_W-1:0];
                REG_MERGE_PORT:   cfg_reg.merge_port     <= pwdata[PORT_W-1:0];
                REG_WARMUP_LEN:   cfg_reg.warmup_length  <= pwdata[CNT_W-1:0];
                REG_FALLBACK_MAX: cfg_reg.distinct_limit <= pwdata[CNT_W-1:0];
                default:          cfg_reg.cold_shards    <= cfg_reg.cold_shards;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_COLD_SHARDS:  prdata = 32'(cfg_reg.cold_shards);
            REG_MERGE_PORT:   prdata = 32'(cfg_reg.merge_port);
            REG_WARMUP_LEN:   prdata = 32'(cfg_reg.warmup_length);
            REG_FALLBACK_MAX: prdata = 32'(cfg_reg.distinct_limit);
            default:          prdata = '0;
        endcase
    end

    hksr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .accept_en   (accept_en),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .key_hash    (key_hash),
        .key_value   (key_value),
        .chunk_start (chunk_start),
        .push        (push),
        .push_item   (push_item),
        .q_full      (q_full)
    );

    hksr_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (q_item),
        .empty     (q_empty)
    );

    hksr_back #(
        .COUNT_ENTRIES (COUNT_ENTRIES),
        .HOT_ENTRIES   (HOT_ENTRIES),
        .MIN_HOT       (MIN_HOT)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .accept_en       (accept_en),
        .q_empty         (q_empty),
        .q_item          (q_item),
        .q_pop           (q_pop),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .dest_port       (dest_port),
        .is_hot          (is_hot),
        .fallback_active (fallback_active),
        .warmup_done     (warmup_done),
        .table_full      (table_full)
    );

endmodule

`default_nettype wire
